/* rtl/nfse_pkg.sv */
`timescale 1ns / 1ps

package nfse_pkg;

   // frame widths
   localparam int unsigned ADDR_W = 7;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CRC_W  = 16;

   // crc-16, reflected form
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

   // slip codes
   localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
   localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
   localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
   localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

   // one byte into the crc, lsb first
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         fb = c[0] ^ data[i];
         c  = {1'b0, c[CRC_W-1:1]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/nsp_frame_slip_encoder_unit.sv */
`timescale 1ns / 1ps

// an accepted item is held in the item register; its result bytes leave from the output register
// throughput: one result byte per cycle from the output register while rsp_tready
//   is high; an item holds the expander until it has made all its bytes (1 or 2,
//   up to 7 on the last byte of a frame), and the next item is taken as its last byte goes
// reset: synchronous, active high; crc returns to 0xFFFF and no frame is open
module nsp_frame_slip_encoder_unit
   import nfse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // wheel_addr[6:0], msg_byte[14:7], zero pad[15]
   input  logic        req_tlast,   // last_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], target_addr[14:8], zero pad[15]
   output logic        rsp_tlast,   // run_end
   output logic        rsp_tuser    // frame_end
);

   typedef enum logic [1:0] {
      PH_MSG,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_END
   } phase_type;

   // frame state
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              in_frame_ff, in_frame_in;

   // item register
   logic              item_valid_ff;
   logic [ADDR_W-1:0] item_addr_ff;
   logic [BYTE_W-1:0] item_byte_ff;
   logic              item_last_ff;
   logic [CRC_W-1:0]  item_crc_ff;

   // expander position
   phase_type         phase_ff, phase_in;
   logic              second_ff, second_in;

   // output register
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic              out_run_end_ff;
   logic              out_frame_end_ff;

   logic [ADDR_W-1:0] req_addr;
   logic [BYTE_W-1:0] req_byte;
   logic [CRC_W-1:0]  crc_start;
   logic [CRC_W-1:0]  crc_after;
   logic              accept;
   logic              advance;
   logic [BYTE_W-1:0] cur_byte;
   logic              needs_esc;
   logic              byte_done;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_run_end;
   logic              emit_frame_end;

   assign req_addr = req_tdata[ADDR_W-1:0];
   assign req_byte = req_tdata[ADDR_W+BYTE_W-1:ADDR_W];

   // crc over destination (first item of a frame) and message byte
   always_comb begin
      crc_start = in_frame_ff ? crc_ff : crc_feed(crc_ff, {1'b0, req_addr});
      crc_after = crc_feed(crc_start, req_byte);
   end

   // pick the byte of the current phase and escape it
   always_comb begin
      case (phase_ff)
         PH_MSG:    cur_byte = item_byte_ff;
         PH_CRC_LO: cur_byte = item_crc_ff[BYTE_W-1:0];
         PH_CRC_HI: cur_byte = item_crc_ff[CRC_W-1:BYTE_W];
         PH_END:    cur_byte = SLIP_END;
         default:   cur_byte = SLIP_END;
      endcase
      needs_esc = (phase_ff != PH_END) && (cur_byte == SLIP_END || cur_byte == SLIP_ESC);
      if (phase_ff == PH_END) begin
         emit_byte = SLIP_END;
      end else if (second_ff) begin
         emit_byte = (cur_byte == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
      end else if (needs_esc) begin
         emit_byte = SLIP_ESC;
      end else begin
         emit_byte = cur_byte;
      end
      byte_done      = !needs_esc || second_ff;
      emit_frame_end = (phase_ff == PH_END);
      emit_run_end   = byte_done &&
                       ((phase_ff == PH_END) || (phase_ff == PH_MSG && !item_last_ff));
   end

   // handshake
   assign advance    = item_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || (advance && emit_run_end);
   assign accept     = req_tvalid && req_tready;

   // next expander position and frame state
   always_comb begin
      phase_in    = phase_ff;
      second_in   = second_ff;
      crc_in      = crc_ff;
      in_frame_in = in_frame_ff;
      if (advance) begin
         if (emit_run_end) begin
            phase_in  = PH_MSG;
            second_in = 1'b0;
         end else if (!byte_done) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            case (phase_ff)
               PH_MSG:    phase_in = PH_CRC_LO;
               PH_CRC_LO: phase_in = PH_CRC_HI;
               PH_CRC_HI: phase_in = PH_END;
               default:   phase_in = PH_MSG;
            endcase
         end
      end
      if (accept) begin
         crc_in      = req_tlast ? CRC_INIT : crc_after;
         in_frame_in = !req_tlast;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= CRC_INIT;
         in_frame_ff   <= 1'b0;
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_MSG;
         second_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         in_frame_ff <= in_frame_in;
         phase_ff    <= phase_in;
         second_ff   <= second_in;
         if (accept) begin
            item_valid_ff <= 1'b1;
            item_addr_ff  <= req_addr;
            item_byte_ff  <= req_byte;
            item_last_ff  <= req_tlast;
            item_crc_ff   <= crc_after;
         end else if (advance && emit_run_end) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff     <= 1'b1;
            out_byte_ff      <= emit_byte;
            out_addr_ff      <= item_addr_ff;
            out_run_end_ff   <= emit_run_end;
            out_frame_end_ff <= emit_frame_end;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result port
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_addr_ff, out_byte_ff};
   assign rsp_tlast  = out_run_end_ff;
   assign rsp_tuser  = out_frame_end_ff;

endmodule
